/* rtl/gbn_sw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N sender window package
// Shared item types, codes, sizes and the control and status bundles that
// pass between the window controller and its datapath.
// ----------------------------------------------------------------------------
package gbn_sw_pkg;

    // Packet payload size and window limit.
    localparam int PACKET_BYTES = 1024;
    localparam int PKT_SHIFT    = $clog2(PACKET_BYTES);
    localparam int MAX_WINDOW   = 16;

    // Field widths.
    localparam int SEQ_W  = 15;
    localparam int WIN_W  = 5;
    localparam int FLEN_W = 24;
    localparam int NLEN_W = 8;
    localparam int LEN_W  = 11;
    localparam int CFG_W  = 24;

    // Event codes.
    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_ACK      = 2'd1,
        OP_TIMEOUT  = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    // Packet kinds.
    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_FINAL = 2'd2
    } kind_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] CFG_FILE_LENGTH = 2'd1;
    localparam logic [1:0] CFG_NAME_LENGTH = 2'd2;

    // One input event item.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] ack_number;
    } in_item_t;

    // One send command item.
    typedef struct packed {
        logic [SEQ_W-1:0]  seq_number;
        logic [1:0]        kind;
        logic [LEN_W-1:0]  length;
        logic [FLEN_W-1:0] data_offset;
        logic              retransmit;
        logic              last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
        logic emit;
        logic emit_final;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ignore;
        logic more;
        logic can_send;
        logic send_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/go_back_n_sender_window_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N sender window unit
// Takes start, acknowledgement and timeout events on s_ and issues the send
// commands that the window then allows on m_.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on s_valid/s_ready/s_data, one item at a time. Send commands
//   leave on m_valid/m_ready/m_data; the last command of an event has last set.
//   Configuration is written through cfg_valid/cfg_index/cfg_data, which is
//   always ready; write it only while no event is in progress.
//   An event runs through setup (capture, window update, final check) and then
//   issues one send command per cycle while the window allows and the output
//   register is free. An ignored event returns to idle without a window
//   update, and an event whose window allows no send issues no command.
//   The next event is accepted while the last command still waits in the
//   output register. When the receiver stalls, the command loop holds until
//   the output register drains.
//   Reset restores the register defaults (window 4, file length 1, name
//   length 0) and leaves the unit idle until a start event.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  gbn_sw_pkg::in_item_t    s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output gbn_sw_pkg::out_item_t   m_data,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [1:0]               cfg_index,
    input  wire [gbn_sw_pkg::CFG_W-1:0] cfg_data
);
    import gbn_sw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Event sequencer.
    gbn_sw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Window state, configuration and output register.
    gbn_sw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

/* rtl/gbn_sw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N sender window controller
// Sequences one event: capture, window update, final check, then one send
// command per cycle while the window allows and the output register is free.
// ----------------------------------------------------------------------------
module gbn_sw_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  gbn_sw_pkg::dp_status_t  status,
    output gbn_sw_pkg::ctrl_cmd_t   cmd
);
    import gbn_sw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CHECK,
        ST_SEND,
        ST_FINAL
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    assign s_ready = ready_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                    ready_next  = 1'b0;
                end
            end
            ST_APPLY: begin
                if (status.ignore) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end else begin
                    cmd.apply  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.more ? ST_SEND : ST_FINAL;
            end
            ST_SEND: begin
                if (!status.can_send) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.send_last) begin
                        state_next = ST_IDLE;
                        ready_next = 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                if (status.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                    ready_next     = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/gbn_sw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Go-Back-N sender window datapath
// Holds the configuration registers, the window state and the output
// register, and builds each send command from the send pointer.
// ----------------------------------------------------------------------------
module gbn_sw_datapath (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  gbn_sw_pkg::in_item_t    s_data,
    output gbn_sw_pkg::out_item_t   m_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [1:0]               cfg_index,
    input  wire [gbn_sw_pkg::CFG_W-1:0] cfg_data,
    input  gbn_sw_pkg::ctrl_cmd_t   cmd,
    output gbn_sw_pkg::dp_status_t  status
);
    import gbn_sw_pkg::*;

    // Configuration registers.
    logic [WIN_W-1:0]  wsize_reg;
    logic [FLEN_W-1:0] flen_reg;
    logic [NLEN_W-1:0] nlen_reg;

    // Captured event.
    logic [1:0]  op_reg;
    logic [15:0] ack_reg;

    // Window state. The last acknowledged sequence is always base - 1.
    logic [SEQ_W-1:0] base_reg, base_next;
    logic [WIN_W-1:0] wl_reg, wl_next;
    logic [SEQ_W-1:0] nts_reg, nts_next;
    logic             any_sent_reg, any_sent_next;
    logic             finished_reg, finished_next;

    // Output register.
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // Derived values.
    logic [FLEN_W-1:0] flen_m1;
    logic [SEQ_W-1:0]  npk;
    logic [SEQ_W-1:0]  npk_m1;
    logic [SEQ_W:0]    win_end;
    logic [SEQ_W:0]    nts_p1;
    logic [SEQ_W-1:0]  nts_m1;
    logic [FLEN_W-1:0] data_off;
    logic [FLEN_W-1:0] data_rem;
    logic [LEN_W-1:0]  data_len;
    logic              ack_hit;
    logic [WIN_W-1:0]  wsize_clamped;
    out_item_t         send_item;
    out_item_t         final_item;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Packet count: name, data slices, final. Empty file counts as one slice.
    assign flen_m1 = flen_reg - FLEN_W'(1);
    assign npk     = (flen_reg == '0) ? SEQ_W'(3)
                                      : SEQ_W'(flen_m1 >> PKT_SHIFT) + SEQ_W'(3);
    assign npk_m1  = npk - SEQ_W'(1);

    // Window bounds and send pointer lookahead.
    assign win_end = {1'b0, base_reg} + (SEQ_W+1)'(wl_reg);
    assign nts_p1  = {1'b0, nts_reg} + (SEQ_W+1)'(1);
    assign nts_m1  = nts_reg - SEQ_W'(1);

    // Status for the controller.
    assign status.ignore    = (op_reg == OP_RESERVED) || (finished_reg && (op_reg != OP_START));
    assign status.more      = ({1'b0, base_reg} + (SEQ_W+1)'(1)) < {1'b0, npk};
    assign status.can_send  = (nts_reg < npk_m1) && ({1'b0, nts_reg} < win_end)
                              && (nts_reg >= base_reg);
    assign status.send_last = !((nts_p1 < {1'b0, npk_m1}) && (nts_p1 < win_end));
    assign status.out_free  = !m_valid_reg || m_ready;

    // Acknowledgement is in order exactly when it names the window base.
    assign ack_hit       = (ack_reg == {1'b0, base_reg});
    assign wsize_clamped = (wsize_reg > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : wsize_reg;

    // Data slice offset and length.
    assign data_off = FLEN_W'({nts_m1, {PKT_SHIFT{1'b0}}});
    assign data_rem = flen_reg - data_off;
    assign data_len = (data_rem < FLEN_W'(PACKET_BYTES)) ? LEN_W'(flen_reg[PKT_SHIFT-1:0])
                                                         : LEN_W'(PACKET_BYTES);

    // Send command for the packet at the send pointer.
    always_comb begin
        send_item            = '0;
        send_item.seq_number = nts_reg;
        send_item.retransmit = (nts_reg == base_reg) && any_sent_reg;
        send_item.last       = status.send_last;
        if (nts_reg == '0) begin
            send_item.kind        = KIND_NAME;
            send_item.length      = LEN_W'(nlen_reg);
            send_item.data_offset = '0;
        end else begin
            send_item.kind        = KIND_DATA;
            send_item.length      = data_len;
            send_item.data_offset = data_off;
        end
    end

    // Final packet command.
    always_comb begin
        final_item            = '0;
        final_item.seq_number = npk_m1;
        final_item.kind       = KIND_FINAL;
        final_item.last       = 1'b1;
    end

    // Window state update.
    always_comb begin
        base_next     = base_reg;
        wl_next       = wl_reg;
        nts_next      = nts_reg;
        any_sent_next = any_sent_reg;
        finished_next = finished_reg;
        if (cmd.apply) begin
            case (op_reg)
                OP_START: begin
                    base_next     = '0;
                    wl_next       = wsize_clamped;
                    nts_next      = '0;
                    any_sent_next = 1'b0;
                    finished_next = 1'b0;
                end
                OP_ACK: begin
                    if (ack_hit) begin
                        base_next = base_reg + SEQ_W'(1);
                    end
                end
                OP_TIMEOUT: begin
                    nts_next = base_reg;
                end
                default: begin
                    nts_next = nts_reg;
                end
            endcase
        end
        if (cmd.emit) begin
            nts_next      = nts_reg + SEQ_W'(1);
            any_sent_next = 1'b1;
        end
        if (cmd.emit_final) begin
            any_sent_next = 1'b1;
            finished_next = 1'b1;
        end
    end

    // Output register load and drain.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = send_item;
        end else if (cmd.emit_final) begin
            m_valid_next = 1'b1;
            m_data_next  = final_item;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg    <= WIN_W'(4);
            flen_reg     <= FLEN_W'(1);
            nlen_reg     <= '0;
            base_reg     <= '0;
            wl_reg       <= '0;
            nts_reg      <= '0;
            any_sent_reg <= 1'b0;
            finished_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW_SIZE: wsize_reg <= cfg_data[WIN_W-1:0];
                    CFG_FILE_LENGTH: flen_reg  <= cfg_data[FLEN_W-1:0];
                    CFG_NAME_LENGTH: nlen_reg  <= cfg_data[NLEN_W-1:0];
                    default: begin
                        wsize_reg <= wsize_reg;
                    end
                endcase
            end
            base_reg     <= base_next;
            wl_reg       <= wl_next;
            nts_reg      <= nts_next;
            any_sent_reg <= any_sent_next;
            finished_reg <= finished_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_data.op;
            ack_reg <= s_data.ack_number;
        end
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

/* tb/sv/go_back_n_sender_window_unit_tb.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender window unit testbench
// Drives start, acknowledgement and timeout items into the window unit and
// compares every send command against an in-bench prediction of the window.
// A directed opening covers the corner cases, then random transfers follow,
// with random sender bursts, receiver stalls and register settings.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_sw_pkg::*;

    // Tracks the sender window and holds the send commands still owed.
    class window_tracker;
        logic [WIN_W-1:0]  win_cfg;
        logic [FLEN_W-1:0] flen_cfg;
        logic [NLEN_W-1:0] nlen_cfg;
        int                win_lo;
        int                win_hi;
        int                ack_seen;
        int                send_ptr;
        bit                sent_once;
        bit                idle;
        out_item_t         pending_cmds[$];
        int                mismatches;

        function new();
            win_cfg    = 5'd4;
            flen_cfg   = 24'd1;
            nlen_cfg   = 8'd0;
            win_lo     = 0;
            win_hi     = 0;
            ack_seen   = -1;
            send_ptr   = 0;
            sent_once  = 1'b0;
            idle       = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_WINDOW_SIZE: win_cfg  = val[WIN_W-1:0];
                CFG_FILE_LENGTH: flen_cfg = val[FLEN_W-1:0];
                CFG_NAME_LENGTH: nlen_cfg = val[NLEN_W-1:0];
                default: ;
            endcase
        endfunction

        // True when the window lets sequence s go out now.
        function bit may_send(int s, longint npk);
            return (s < npk - 1) && (s <= win_hi) && (s >= win_lo);
        endfunction

        function void owe_cmd(longint seq, kind_t kind, longint len, longint off,
                              bit retx, bit last);
            out_item_t c;
            c.seq_number  = seq[SEQ_W-1:0];
            c.kind        = kind;
            c.length      = len[LEN_W-1:0];
            c.data_offset = off[FLEN_W-1:0];
            c.retransmit  = retx;
            c.last        = last;
            pending_cmds.push_back(c);
        endfunction

        // Applies one accepted event and queues the send commands it causes.
        function void take_event(in_item_t ev);
            int     ack;
            int     w;
            longint fl;
            longint npk;
            longint off;
            longint len;
            bit     retx;
            bit     last;

            ack = $signed(ev.ack_number);
            fl  = flen_cfg;
            npk = (fl - 1) / PACKET_BYTES + 3;

            if (ev.op == OP_START) begin
                w         = (win_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg);
                win_lo    = 0;
                win_hi    = w - 1;
                ack_seen  = -1;
                send_ptr  = 0;
                sent_once = 1'b0;
                idle      = 1'b0;
            end else if (ev.op == OP_RESERVED || idle) begin
                return;
            end else if (ev.op == OP_ACK) begin
                // Only the next in-order acknowledgement slides the window.
                if (ack == ack_seen + 1 && ack >= win_lo) begin
                    win_hi   += ack + 1 - win_lo;
                    win_lo    = ack + 1;
                    ack_seen += 1;
                end
            end else begin
                send_ptr = win_lo;
            end

            if (ack_seen + 2 < npk) begin
                while (may_send(send_ptr, npk)) begin
                    retx = (send_ptr == win_lo) && sent_once;
                    last = !may_send(send_ptr + 1, npk);
                    if (send_ptr == 0) begin
                        owe_cmd(0, KIND_NAME, nlen_cfg, 0, retx, last);
                    end else begin
                        off = longint'(send_ptr - 1) * PACKET_BYTES;
                        len = (fl - off < PACKET_BYTES) ? fl % PACKET_BYTES : PACKET_BYTES;
                        owe_cmd(send_ptr, KIND_DATA, len, off, retx, last);
                    end
                    send_ptr++;
                    sent_once = 1'b1;
                end
            end else begin
                // Second-to-last packet acknowledged: close the transfer.
                owe_cmd(npk - 1, KIND_FINAL, 0, 0, 1'b0, 1'b1);
                sent_once = 1'b1;
                idle      = 1'b1;
            end
        endfunction

        function void check_field(string what, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                mismatches++;
            end
        endfunction

        // Compares one accepted send command with the oldest one owed.
        function void match_command(out_item_t got);
            out_item_t want;
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected send command, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = pending_cmds.pop_front();
            check_field("seq_number", want.seq_number, got.seq_number);
            check_field("kind", want.kind, got.kind);
            check_field("length", want.length, got.length);
            check_field("data_offset", want.data_offset, got.data_offset);
            check_field("retransmit", want.retransmit, got.retransmit);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    in_item_t        s_data;
    logic            m_valid;
    logic            m_ready;
    out_item_t       m_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [1:0]      cfg_index;
    logic [CFG_W-1:0] cfg_data;

    window_tracker   sb = new();
    int              n_events = 0;
    int              burst_left = 4;
    bit              steady = 1'b0;
    bit              park_rx = 1'b0;

    go_back_n_sender_window_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Offers one event item, waits for it to be taken, then paces the sender.
    task automatic offer(op_t op, logic signed [15:0] ackv);
        in_item_t it;
        it.op         = op;
        it.ack_number = ackv;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_START || (op != OP_RESERVED && !sb.idle)) n_events++;
        sb.take_event(it);
        burst_left--;
        if (!steady && burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stops offering and waits until every owed command has come out.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Writes all three registers; unused upper bits sometimes carry junk.
    task automatic program_regs(logic [4:0] w, logic [23:0] fl, logic [7:0] nl);
        logic [23:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'd0;
        put_reg(CFG_WINDOW_SIZE, {junk[23:5], w});
        put_reg(CFG_FILE_LENGTH, fl);
        put_reg(CFG_NAME_LENGTH, {junk[15:0], nl});
        cfg_valid <= 1'b0;
    endtask

    // Output monitor: every accepted send command is checked.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.match_command(m_data);
    end

    // Receiver pacing, with a long hold-off on request.
    initial begin
        int mode;
        int span;
        mode    = 0;
        span    = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (park_rx) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                park_rx = 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 96);
                end
                span--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Hard limit on run time.
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main stimulus.
    initial begin
        int                 phase;
        int                 budget;
        int                 r;
        int                 waited;
        logic [4:0]         w;
        logic [23:0]        fl;
        logic signed [15:0] av;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle unit ignores everything but start; then a one-byte file.
        offer(OP_ACK, 16'sd0);
        offer(OP_TIMEOUT, 16'sd0);
        offer(OP_RESERVED, -16'sd1);
        offer(OP_START, 16'sd0);
        offer(OP_RESERVED, 16'sd0);
        offer(OP_ACK, -16'sd1);
        offer(OP_ACK, 16'sh7FFF);
        offer(OP_ACK, 16'sh8000);
        offer(OP_TIMEOUT, 16'sd0);
        offer(OP_ACK, 16'sd0);
        offer(OP_ACK, 16'sd1);
        offer(OP_START, 16'sd0);
        offer(OP_START, 16'sd0);
        settle();

        // Oversized window, empty file, longest name.
        program_regs(5'd31, 24'd0, 8'd255);
        offer(OP_START, 16'sd0);
        offer(OP_ACK, 16'sd0);
        offer(OP_ACK, 16'sd1);
        settle();

        // Zero window: acknowledgements run ahead of anything sent.
        program_regs(5'd0, 24'd5000, 8'd149);
        offer(OP_START, 16'sd0);
        offer(OP_ACK, 16'sd0);
        offer(OP_TIMEOUT, 16'sd0);
        for (int i = 1; i <= 5; i++) offer(OP_ACK, 16'(i));
        settle();

        // Full window over the largest file.
        program_regs(5'd16, 24'hFFFFFF, 8'd1);
        offer(OP_START, 16'sd0);
        offer(OP_ACK, 16'sd16385);
        settle();

        // Random transfers, one register setting per phase.
        phase = 0;
        n_events = 0;
        while (n_events < 450) begin
            settle();
            r  = $urandom_range(0, 9);
            w  = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(1, 16));
            r  = $urandom_range(0, 19);
            fl = (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFFFF : (r == 2) ? 24'($urandom())
               : (r < 8) ? 24'($urandom_range(1, 3000)) : 24'($urandom_range(1, 20000));
            if (phase == 2) begin
                w  = 5'd16;
                fl = 24'd20000;
            end
            program_regs(w, fl, 8'($urandom_range(0, 255)));
            if (phase == 2) begin
                // Receiver holds off while the sender keeps pushing.
                park_rx = 1'b1;
                steady  = 1'b1;
            end
            offer(OP_START, 16'sd0);
            budget = $urandom_range(10, 60);
            for (int i = 0; i < budget && n_events < 450; i++) begin
                if (sb.idle) begin
                    if ($urandom_range(0, 1) == 1)
                        offer(op_t'($urandom_range(0, 1) ? OP_ACK : OP_TIMEOUT),
                              16'($urandom()));
                    break;
                end
                r = $urandom_range(0, 99);
                if (r < 62) begin
                    av = 16'(sb.ack_seen + 1);
                    offer(OP_ACK, av);
                end else if (r < 72) begin
                    offer(OP_TIMEOUT, 16'($urandom()));
                end else if (r < 78) begin
                    av = 16'(sb.ack_seen);
                    offer(OP_ACK, av);
                end else if (r < 84) begin
                    av = 16'(sb.ack_seen + 1 + $urandom_range(1, 4));
                    offer(OP_ACK, av);
                end else if (r < 90) begin
                    offer(OP_ACK, 16'($urandom()));
                end else if (r < 94) begin
                    offer(OP_RESERVED, 16'($urandom()));
                end else begin
                    offer(OP_START, 16'($urandom()));
                end
            end
            steady = 1'b0;
            phase++;
        end

        // Drain what is still owed, with a bound.
        s_valid <= 1'b0;
        waited = 0;
        while (sb.pending_cmds.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (sb.pending_cmds.size() != 0) begin
            $display("%0t: %0d send commands never came, expected %p, actual none",
                     $time, sb.pending_cmds.size(), sb.pending_cmds[0]);
            sb.mismatches += sb.pending_cmds.size();
        end

        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
